/* src/utcl_pkg.sv */
// Shared types, constants and calendar helper functions for the UTC to local time converter.
package utcl_pkg;

  // Field widths of one timestamp.
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  // Stream widths: fields packed from the lowest bit, padded to whole bytes.
  localparam int unsigned FieldsW = YearW + MonthW + DayW + HourW + MinuteW + SecondW;
  localparam int unsigned TdataW  = ((FieldsW + 7) / 8) * 8;
  localparam int unsigned PadW    = TdataW - FieldsW;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] CFG_STD_OFFSET   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SUMMER_EXTRA = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SWITCH_HOUR  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DST_ENABLE   = 2'd3;

  // Register values after reset.
  localparam logic [3:0] StdOffsetRst   = 4'd1;
  localparam logic       SummerExtraRst = 1'b1;
  localparam logic [4:0] SwitchHourRst  = 5'd1;
  localparam logic       DstEnableRst   = 1'b1;

  // Month codes used by the summer time rule.
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthOct = 4'd10;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [5:0] HoursPerDay = 6'd24;

  // Multiplicative inverse of 25 modulo 2**12, and the largest multiple quotient.
  localparam logic [YearW-1:0] Inv25   = 12'd3113;
  localparam logic [YearW-1:0] Max25Q  = 12'd163;

  // Live configuration registers.
  typedef struct packed {
    logic [3:0] std_offset;
    logic       summer_extra;
    logic [4:0] switch_hour;
    logic       dst_enable;
  } cfg_t;

  // One timestamp, UTC or local.
  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } stamp_t;

  // Remainder modulo 7 of a 15-bit value: 8 is 1 modulo 7, so octal digits add up.
  function automatic logic [2:0] mod7(input logic [14:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
    return (s3 == 4'd7) ? 3'd0 : s3[2:0];
  endfunction

  // Gregorian leap year. Divisibility by 25 is tested by multiplying with the
  // inverse of 25: the product is small exactly for multiples of 25.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] q;
    logic             div4;
    logic             div100;
    logic             div400;
    q      = YearW'(y * Inv25);
    div4   = (y[1:0] == 2'd0);
    div100 = div4 && (q <= Max25Q);
    div400 = div100 && (y[3:0] == 4'd0);
    return (div4 && !div100) || div400;
  endfunction

  // Days in a month; codes that are no month count as 31 days.
  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                   input logic [YearW-1:0]  y);
    logic [DayW-1:0] len;
    case (m)
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      MonthFeb: len = is_leap(y) ? 5'd29 : 5'd28;
      default:  len = 5'd31;
    endcase
    return len;
  endfunction

  // Day of month of the last Sunday, with 4 for March and 1 for October.
  function automatic logic [DayW-1:0] last_sunday(input logic [YearW-1:0] y,
                                                  input logic [2:0]       k);
    logic [14:0] t;
    t = 15'(y) + 15'(y[YearW-1:2]) + 15'(k);
    return 5'd31 - 5'(mod7(t));
  endfunction

endpackage

/* src/utcl_convert.sv */
// Combinational conversion of one UTC timestamp to local time with summer time.
module utcl_convert import utcl_pkg::*; (
  input  cfg_t   cfg_i,
  input  stamp_t utc_i,
  output stamp_t loc_o,
  output logic   summer_o
);

  logic [DayW-1:0]   last_mar;
  logic [DayW-1:0]   last_oct;
  logic              in_summer;
  logic [5:0]        hour_sum;
  logic              wrap;
  logic [5:0]        day_inc;
  logic              month_end;
  logic [4:0]        month_next;
  logic              year_end;

  // Summer time window: April to September whole, March and October by last Sunday.
  always_comb begin
    last_mar = last_sunday(utc_i.year, 3'd4);
    last_oct = last_sunday(utc_i.year, 3'd1);
    if ((utc_i.month > MonthMar) && (utc_i.month < MonthOct)) begin
      in_summer = 1'b1;
    end else if (utc_i.month == MonthMar) begin
      in_summer = (utc_i.day > last_mar) ||
                  ((utc_i.day == last_mar) && (utc_i.hour >= cfg_i.switch_hour));
    end else if (utc_i.month == MonthOct) begin
      in_summer = (utc_i.day < last_oct) ||
                  ((utc_i.day == last_oct) && (utc_i.hour < cfg_i.switch_hour));
    end else begin
      in_summer = 1'b0;
    end
  end

  assign summer_o = cfg_i.dst_enable && in_summer;

  // Hour offset; the sum stays below 48, so one subtraction wraps it.
  assign hour_sum = 6'(utc_i.hour) + 6'(cfg_i.std_offset) +
                    6'(summer_o ? cfg_i.summer_extra : 1'b0);
  assign wrap     = (hour_sum >= HoursPerDay);

  // Date rollover by one day.
  assign day_inc    = 6'(utc_i.day) + 6'd1;
  assign month_end  = (day_inc > 6'(month_length(utc_i.month, utc_i.year)));
  assign month_next = month_end ? 5'(utc_i.month) + 5'd1 : 5'(utc_i.month);
  assign year_end   = (month_next > 5'(MonthDec));

  always_comb begin
    loc_o.minute = utc_i.minute;
    loc_o.second = utc_i.second;
    if (wrap) begin
      loc_o.hour  = HourW'(hour_sum - HoursPerDay);
      loc_o.day   = month_end ? 5'd1 : day_inc[DayW-1:0];
      loc_o.month = year_end ? 4'd1 : month_next[MonthW-1:0];
      loc_o.year  = year_end ? utc_i.year + 12'd1 : utc_i.year;
    end else begin
      loc_o.hour  = hour_sum[HourW-1:0];
      loc_o.day   = utc_i.day;
      loc_o.month = utc_i.month;
      loc_o.year  = utc_i.year;
    end
  end

endmodule

/* src/utc_to_local_time_with_dst_unit.sv */
// Top level: UTC to local time converter with summer time, stream in and out.
//
//   Channel   Direction  Content
//   s_axis    in         UTC timestamp in tdata
//   m_axis    out        local timestamp in tdata, summer time flag in tuser
//   cfg       in         register write: enable, index, data
//
// One timestamp per cycle is sustained while m_axis_tready is high; each passes
// through an input register, the conversion logic and the result register.
// Reset clears both valid flags and loads the register defaults.
// A stalled result holds; the input stage keeps accepting until both stages are full.
module utc_to_local_time_with_dst_unit import utcl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata from bit 0: utc_year, utc_month, utc_day, utc_hour, utc_minute, utc_second.
  input  logic [TdataW-1:0]   s_axis_tdata,
  // Output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata from bit 0: local_year, local_month, local_day, local_hour, local_minute,
  // local_second.
  output logic [TdataW-1:0]   m_axis_tdata,
  // tuser bit 0: summer_time.
  output logic                m_axis_tuser,
  // Configuration writes.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t   cfg_q;
  stamp_t in_q;
  logic   in_valid_q;
  logic   in_valid_d;
  stamp_t out_q;
  logic   summer_q;
  logic   out_valid_q;
  logic   out_valid_d;
  stamp_t in_unpacked;
  stamp_t conv_loc;
  logic   conv_summer;
  logic   out_ready;
  logic   in_take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.std_offset   <= StdOffsetRst;
      cfg_q.summer_extra <= SummerExtraRst;
      cfg_q.switch_hour  <= SwitchHourRst;
      cfg_q.dst_enable   <= DstEnableRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STD_OFFSET:   cfg_q.std_offset   <= cfg_wdata_i[3:0];
        CFG_SUMMER_EXTRA: cfg_q.summer_extra <= cfg_wdata_i[0];
        CFG_SWITCH_HOUR:  cfg_q.switch_hour  <= cfg_wdata_i[4:0];
        CFG_DST_ENABLE:   cfg_q.dst_enable   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the result stage frees when empty or taken, the input stage behind it.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_take ? 1'b1 : (out_ready ? 1'b0 : in_valid_q);
    out_valid_d = out_ready ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input field unpacking.
  always_comb begin
    in_unpacked.year   = s_axis_tdata[11:0];
    in_unpacked.month  = s_axis_tdata[15:12];
    in_unpacked.day    = s_axis_tdata[20:16];
    in_unpacked.hour   = s_axis_tdata[25:21];
    in_unpacked.minute = s_axis_tdata[31:26];
    in_unpacked.second = s_axis_tdata[37:32];
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_unpacked;
    end
  end

  utcl_convert u_convert (
    .cfg_i    (cfg_q),
    .utc_i    (in_q),
    .loc_o    (conv_loc),
    .summer_o (conv_summer)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_q    <= conv_loc;
      summer_q <= conv_summer;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = summer_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_q.second, out_q.minute, out_q.hour,
                          out_q.day, out_q.month, out_q.year};

  // A blocked input means both stages hold a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input blocked while a stage is empty");

  // The local hour is always wrapped into a day.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.hour < HourW'(HoursPerDay)))
    else $error("local hour out of range");

  // Summer time only in March to October and only when enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_summer |-> (cfg_q.dst_enable && (in_q.month >= MonthMar) &&
                     (in_q.month <= MonthOct)))
    else $error("summer time outside its window");

  // A year change lands in January.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (conv_loc.year != in_q.year)) |-> (conv_loc.month == 4'd1))
    else $error("year rolled without a move to January");

endmodule
